/* src/lts_pkg.sv */
`default_nettype none

package lts_pkg;

    // Block sizing
    localparam int LANES         = 8;
    localparam int REPORT_PERIOD = 12;
    localparam int LANE_AW       = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int PHASE_W       = $clog2(REPORT_PERIOD + 1);
    localparam int FRAME_W       = 32;
    localparam int TOTAL_W       = 32;
    localparam int CNT_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    // Configuration register reset values
    localparam logic [7:0] LONG_LIMIT_RST   = 8'd7;
    localparam logic [7:0] MEDIUM_LIMIT_RST = 8'd5;
    localparam logic [7:0] FLOW_LIMIT_RST   = 8'd3;

    // Headway: diff * 0.4 == (2 * diff) / 5, saturating once the quotient passes 254
    localparam int HW_SAT_DIFF = 638;
    localparam int HW_X_W      = 11;
    localparam int HW_RECIP    = 3277;
    localparam int HW_SHIFT    = 14;
    localparam int HW_P_W      = HW_X_W + 12;

    // Occupancy: count * 100 / REPORT_PERIOD through a scaled reciprocal
    localparam int PCT_SCALE = 100;
    localparam int OCC_P_W   = 15;
    localparam int OCC_SHIFT = 24;
    localparam int OCC_Q_W   = OCC_P_W + OCC_SHIFT;
    localparam int OCC_RECIP = ((1 << OCC_SHIFT) + REPORT_PERIOD - 1) / REPORT_PERIOD;

    // Register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_LIMIT   = 2'd0,
        CFG_MEDIUM_LIMIT = 2'd1,
        CFG_FLOW_LIMIT   = 2'd2
    } t_cfg_idx;

    // Head zone presence codes
    localparam logic [1:0] PRES_EMPTY    = 2'd0;
    localparam logic [1:0] PRES_OCCUPIED = 2'd1;
    localparam logic [1:0] PRES_ENTERED  = 2'd2;

    // Vehicle length classes
    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_SHORT  = 2'd1;
    localparam logic [1:0] CLASS_MEDIUM = 2'd2;
    localparam logic [1:0] CLASS_LONG   = 2'd3;

    typedef logic [LANE_AW-1:0] t_lane_addr;

    typedef struct packed {
        logic [7:0] long_length_limit;
        logic [7:0] medium_length_limit;
        logic [7:0] flow_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         lane;
        logic               new_frame;
        logic [1:0]         presence;
        logic               tail_present;
        logic [TOTAL_W-1:0] vehicle_total;
        logic [7:0]         vehicle_length;
        logic [7:0]         queue_length;
        logic [7:0]         speed;
        logic               visibility_fault;
        logic               blur_flag;
    } t_in_item;

    typedef struct packed {
        logic [2:0] lane_out;
        logic       full_report;
        logic [1:0] occupied_bits;
        logic [7:0] queue_out;
        logic [7:0] speed_out;
        logic [7:0] flow;
        logic [1:0] vehicle_class;
        logic [7:0] head_headway;
        logic [7:0] tail_headway;
        logic [7:0] head_occupancy;
        logic [7:0] tail_occupancy;
        logic       data_invalid;
    } t_out_item;

    // One lane's entry in the state memory
    typedef struct packed {
        logic [FRAME_W-1:0] head_last;
        logic [FRAME_W-1:0] head_prev;
        logic [FRAME_W-1:0] tail_last;
        logic [FRAME_W-1:0] tail_prev;
        logic [CNT_W-1:0]   head_count;
        logic [CNT_W-1:0]   tail_count;
        logic [TOTAL_W-1:0] flow_base;
    } t_lane_entry;

    // Hand-over from the lane update stage to the report stage
    typedef struct packed {
        logic [2:0]         lane;
        logic               full;
        logic               lane_ok;
        logic [1:0]         occupied_bits;
        logic               presence_nz;
        logic [7:0]         vehicle_length;
        logic [7:0]         queue_length;
        logic [7:0]         speed;
        logic               invalid;
        logic [TOTAL_W-1:0] vehicle_total;
        logic [TOTAL_W-1:0] old_base;
        t_lane_entry        entry;
    } t_stage;

    // Saturating count increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] res;
        res = (c == '1) ? c : c + CNT_W'(1);
        return res;
    endfunction

    // Headway in seconds from two entry frames, 0 while either slot is empty
    function automatic logic [7:0] headway_sec(input logic [FRAME_W-1:0] last,
                                               input logic [FRAME_W-1:0] prev);
        logic [FRAME_W-1:0] diff;
        logic [HW_X_W-1:0]  x;
        logic [HW_P_W-1:0]  prod;
        logic [7:0]         res;
        diff = last - prev;
        x    = {diff[HW_X_W-2:0], 1'b0};
        prod = HW_P_W'(x) * HW_P_W'(HW_RECIP);
        if (last == '0 || prev == '0) begin
            res = '0;
        end else if (diff >= FRAME_W'(HW_SAT_DIFF)) begin
            res = 8'hFF;
        end else begin
            res = 8'(prod >> HW_SHIFT);
        end
        return res;
    endfunction

    // Occupancy percentage over one report period, saturated at 255
    function automatic logic [7:0] occupancy_pct(input logic [CNT_W-1:0] count);
        logic [OCC_P_W-1:0] p;
        logic [OCC_Q_W-1:0] q;
        logic [OCC_Q_W-1:0] v;
        logic [7:0]         res;
        p   = OCC_P_W'(count) * OCC_P_W'(PCT_SCALE);
        q   = OCC_Q_W'(p) * OCC_Q_W'(OCC_RECIP);
        v   = q >> OCC_SHIFT;
        res = (v > OCC_Q_W'(255)) ? 8'hFF : v[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/lts_in_if.sv */
`default_nettype none

interface lts_in_if;
    import lts_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/lts_out_if.sv */
`default_nettype none

interface lts_out_if;
    import lts_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/lts_ram.sv */
`default_nettype none

module lts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on a collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/lts_lane_update.sv */
`default_nettype none

module lts_lane_update (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lts_in_if.sink       i_in,
    input  wire logic    i_s2_ready,
    output logic         o_s2_valid,
    output lts_pkg::t_stage o_s2
);
    import lts_pkg::*;

    typedef struct packed {
        t_in_item           item;
        logic [FRAME_W-1:0] frame;
        logic               full;
    } t_s1;

    logic               r_s1_valid;
    t_s1                r_s1;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PHASE_W-1:0] phase_inc;
    logic [LANES-1:0]   r_lane_valid;
    logic               r_wr_valid;
    t_lane_addr         r_wr_addr;
    t_lane_entry        r_wr_data;

    logic        accept;
    logic        s1_fire;
    logic        lane_ok;
    logic        fwd_hit;
    logic        wr_en;
    t_lane_addr  rd_addr;
    t_lane_addr  s1_addr;
    t_lane_entry ram_q;
    t_lane_entry cur;
    t_lane_entry upd;
    t_lane_entry wb;

    assign i_in.ready = !r_s1_valid || i_s2_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign s1_fire    = r_s1_valid && i_s2_ready;
    assign rd_addr    = t_lane_addr'(i_in.payload.lane);

    // Frame counter and report phase, advanced when a taken transaction starts a new frame
    assign phase_inc = r_phase + PHASE_W'(1);

    always_comb begin
        n_frame = r_frame;
        n_phase = r_phase;
        if (i_in.payload.new_frame) begin
            n_frame = r_frame + FRAME_W'(1);
            n_phase = (phase_inc >= PHASE_W'(REPORT_PERIOD)) ? '0 : phase_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= '0;
            r_phase    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_frame    <= n_frame;
                r_phase    <= n_phase;
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.item  <= i_in.payload;
            r_s1.frame <= n_frame;
            r_s1.full  <= (n_phase == '0);
        end
    end

    // Per-lane state memory, read on acceptance, written as an item of an in-range lane leaves
    lts_ram #(
        .WIDTH ($bits(t_lane_entry)),
        .DEPTH (LANES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (s1_addr),
        .i_wdata (wb),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign lane_ok = 32'(r_s1.item.lane) < 32'(LANES);
    assign s1_addr = t_lane_addr'(r_s1.item.lane);
    assign fwd_hit = r_wr_valid && (r_wr_addr == s1_addr);
    assign wr_en   = s1_fire && lane_ok;

    // Current entry: unwritten lanes read as zero, latest write bypasses the memory
    always_comb begin
        if (!lane_ok || !r_lane_valid[s1_addr]) begin
            cur = '0;
        end else if (fwd_hit) begin
            cur = r_wr_data;
        end else begin
            cur = ram_q;
        end
    end

    // Entry and occupancy updates
    always_comb begin
        upd = cur;
        if (r_s1.item.presence == PRES_ENTERED) begin
            if (cur.head_last != '0) begin
                upd.head_prev = cur.head_last;
            end
            upd.head_last = r_s1.frame;
        end else if (r_s1.item.presence == PRES_OCCUPIED) begin
            upd.head_count = sat_inc(cur.head_count);
        end
        if (r_s1.item.tail_present) begin
            if (cur.tail_last != '0) begin
                upd.tail_prev = cur.tail_last;
            end
            upd.tail_last  = r_s1.frame;
            upd.tail_count = sat_inc(cur.tail_count);
        end
    end

    // Report frame restarts the counts and the flow baseline
    always_comb begin
        wb = upd;
        if (r_s1.full) begin
            wb.head_count = '0;
            wb.tail_count = '0;
            wb.flow_base  = r_s1.item.vehicle_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_valid <= '0;
            r_wr_valid   <= 1'b0;
        end else if (wr_en) begin
            r_lane_valid[s1_addr] <= 1'b1;
            r_wr_valid            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wr_addr <= s1_addr;
            r_wr_data <= wb;
        end
    end

    // Hand-over to the report stage
    assign o_s2_valid = r_s1_valid;

    always_comb begin
        o_s2.lane           = r_s1.item.lane;
        o_s2.full           = r_s1.full;
        o_s2.lane_ok        = lane_ok;
        o_s2.occupied_bits  = {r_s1.item.tail_present,
                               (r_s1.item.presence == PRES_OCCUPIED)};
        o_s2.presence_nz    = (r_s1.item.presence != PRES_EMPTY);
        o_s2.vehicle_length = r_s1.item.vehicle_length;
        o_s2.queue_length   = r_s1.item.queue_length;
        o_s2.speed          = r_s1.item.speed;
        o_s2.invalid        = r_s1.item.visibility_fault | r_s1.item.blur_flag;
        o_s2.vehicle_total  = r_s1.item.vehicle_total;
        o_s2.old_base       = cur.flow_base;
        o_s2.entry          = upd;
    end

endmodule

`default_nettype wire

/* src/lts_report.sv */
`default_nettype none

module lts_report (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lts_pkg::t_cfg    i_cfg,
    input  wire logic             i_s2_valid,
    input  wire lts_pkg::t_stage  i_s2,
    output logic                  o_s2_ready,
    lts_out_if.source             o_out
);
    import lts_pkg::*;

    logic               r_s2_valid;
    t_stage             r_s2;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               out_free;
    logic               s2_load;
    logic               s2_fire;
    logic [TOTAL_W-1:0] delta;

    assign out_free   = !r_out_valid || o_out.ready;
    assign o_s2_ready = !r_s2_valid || out_free;
    assign s2_load    = i_s2_valid && o_s2_ready;
    assign s2_fire    = r_s2_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2 <= i_s2;
        end
        if (s2_fire) begin
            r_out <= n_out;
        end
    end

    assign delta = r_s2.vehicle_total - r_s2.old_base;

    // Report fields; status-only frames carry lane and occupied bits alone
    always_comb begin
        n_out               = '0;
        n_out.lane_out      = r_s2.lane;
        n_out.full_report   = r_s2.full;
        n_out.occupied_bits = r_s2.occupied_bits;
        if (r_s2.full) begin
            n_out.queue_out    = r_s2.queue_length;
            n_out.speed_out    = r_s2.speed;
            n_out.data_invalid = r_s2.invalid;
            if (!r_s2.presence_nz) begin
                n_out.vehicle_class = CLASS_NONE;
            end else if (r_s2.vehicle_length > i_cfg.long_length_limit) begin
                n_out.vehicle_class = CLASS_LONG;
            end else if (r_s2.vehicle_length > i_cfg.medium_length_limit) begin
                n_out.vehicle_class = CLASS_MEDIUM;
            end else begin
                n_out.vehicle_class = CLASS_SHORT;
            end
            if (r_s2.lane_ok) begin
                // first report after an empty baseline gives no flow
                if (r_s2.old_base != '0) begin
                    n_out.flow = (delta > TOTAL_W'(i_cfg.flow_limit)) ?
                                 i_cfg.flow_limit : delta[7:0];
                end
                n_out.head_headway   = headway_sec(r_s2.entry.head_last,
                                                   r_s2.entry.head_prev);
                n_out.tail_headway   = headway_sec(r_s2.entry.tail_last,
                                                   r_s2.entry.tail_prev);
                n_out.head_occupancy = occupancy_pct(r_s2.entry.head_count);
                n_out.tail_occupancy = occupancy_pct(r_s2.entry.tail_count);
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

/* src/lane_traffic_statistics.sv */
`default_nettype none

// Channel   Dir  Handshake         Payload
// i_in      in   valid/ready       t_in_item: one lane's detector result per frame
// o_out     out  valid/ready       t_out_item: one report per input transaction
// i_cfg_*   in   write enable only index 0..2, 8-bit data; no read-back
//
// One transaction per cycle sustained while the output is not stalled; a result passes the memory read,
// report stage and output register in that order before it is offered at the output.
// Per-lane state sits in one memory; the last write is bypassed to a same-lane read.
// Synchronous active-low reset clears the lane valid bits, frame counter, report phase and pipeline
// valids and presets the configuration; unwritten lanes read as zero, so no clearing pass is needed.
// A stalled output holds its result while the stages behind it keep filling.

module lane_traffic_statistics (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lts_in_if.sink                               i_in,
    lts_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [lts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lts_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lts_pkg::*;

    t_cfg   r_cfg;
    logic   s2_valid;
    logic   s2_ready;
    t_stage s2;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_length_limit   <= LONG_LIMIT_RST;
            r_cfg.medium_length_limit <= MEDIUM_LIMIT_RST;
            r_cfg.flow_limit          <= FLOW_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_LIMIT: begin
                    r_cfg.long_length_limit <= i_cfg_data;
                end
                CFG_MEDIUM_LIMIT: begin
                    r_cfg.medium_length_limit <= i_cfg_data;
                end
                CFG_FLOW_LIMIT: begin
                    r_cfg.flow_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    lts_lane_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_s2_ready (s2_ready),
        .o_s2_valid (s2_valid),
        .o_s2       (s2)
    );

    lts_report u_report (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s2_valid (s2_valid),
        .i_s2       (s2),
        .o_s2_ready (s2_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
